>>> hdl/ridl_pkg.sv
// Shared types and codes for the rank indexed list with delete.
// Holds request/response payload structs, command and status codes,
// and the sequencer state type. No dependencies.
package ridl_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int VALUE_W          = 32;
   localparam int RANK_W           = 10;
   localparam int CMD_W            = 2;
   localparam int STATUS_W         = 2;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANK = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] item_value;
      logic [RANK_W-1:0]         live_rank;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_TREE_RD,
      ST_TREE_CMP,
      ST_TREE_INC,
      ST_VAL_CAP,
      ST_DONE
   } state_type;

endpackage

>>> hdl/ridl_ram.sv
// Generic single write port, single read port RAM with registered read.
// Used for the value store and the deleted-count tree. No dependencies.
module ridl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rank_indexed_list_with_delete.sv
// Top level of the rank indexed list with delete.
// Depends on ridl_pkg (types, codes) and ridl_ram (value store, count tree).
//
//   Request channel (req_*): cmd selects append, read by rank or delete by
//   rank. A request is taken when req_valid is high and req_stall is low.
//   Response channel (rsp_*): one response per request, with a status and,
//   for a successful read, the value found.
//   Append, unused commands and rank errors go from decode straight to the
//   response; read and delete first descend the count tree level by level,
//   reading the left child's count and comparing (a delete also increments
//   the child it takes, reading the right child first when it turns right),
//   and a read then fetches the leaf value. With 1024 entries the tree has
//   10 levels. One request is in flight at a time.
//   Reset: a clearing pass zeroes the count tree, one node per cycle, so
//   req_stall stays high after reset until all 2*CAPACITY-1 nodes (4*CAPACITY
//   when CAPACITY is not a power of two) are cleared.
//   Receiver stall: a finished response waits in the output register; the
//   block still takes the next request and holds its result until the
//   output register frees up.
module rank_indexed_list_with_delete #(
   parameter int CAPACITY = ridl_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ridl_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ridl_pkg::rsp_type rsp_payload
);

   import ridl_pkg::*;

   // count, slot and node widths
   localparam int CW         = $clog2(CAPACITY + 1);
   localparam int SW         = $clog2(CAPACITY);
   localparam bit POW2       = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam int TREE_DEPTH = POW2 ? 2 * CAPACITY - 1 : 4 * CAPACITY;
   localparam int NW         = $clog2(TREE_DEPTH);
   localparam int KW         = (CW > RANK_W) ? CW : RANK_W;

   localparam logic [NW-1:0] TREE_LAST = NW'(TREE_DEPTH - 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [SW-1:0] SLOT_LAST = SW'(CAPACITY - 1);

   state_type state_ff, state_in;

   req_type          req_ff, req_in;
   rsp_type          result_ff, result_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    fill_ff, fill_in;          // appended entries
   logic [CW-1:0]    del_total_ff, del_total_in; // root of the count tree
   logic [NW-1:0]    node_ff, node_in;
   logic [SW-1:0]    lo_ff, lo_in;
   logic [SW-1:0]    hi_ff, hi_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [NW-1:0]    clr_ff, clr_in;

   // RAM ports
   logic             val_wr_en;
   logic [SW-1:0]    val_wr_addr;
   logic [VALUE_W-1:0] val_wr_data;
   logic             val_rd_en;
   logic [VALUE_W-1:0] val_rd_data;
   logic             tree_wr_en;
   logic [NW-1:0]    tree_wr_addr;
   logic [CW-1:0]    tree_wr_data;
   logic             tree_rd_en;
   logic [NW-1:0]    tree_rd_addr;
   logic [CW-1:0]    tree_rd_data;

   // shared descent unit
   logic             accept;
   logic             mark;
   logic             rsp_free;
   logic [CW-1:0]    live;
   logic [SW-1:0]    mid;
   logic [NW-1:0]    left_node;
   logic [CW-1:0]    top_full;
   logic [SW-1:0]    top;
   logic [CW-1:0]    filled_left;
   logic [CW-1:0]    left_live;
   logic             go_left;
   logic             rank_bad;

   ridl_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (lo_ff),
      .rd_data (val_rd_data)
   );

   ridl_ram #(
      .WIDTH (CW),
      .DEPTH (TREE_DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_wr_en),
      .wr_addr (tree_wr_addr),
      .wr_data (tree_wr_data),
      .rd_en   (tree_rd_en),
      .rd_addr (tree_rd_addr),
      .rd_data (tree_rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign mark        = (req_ff.cmd == CMD_DELETE);

   // live entries overall; check the held request's rank before the descent
   assign live     = (del_total_ff < fill_ff) ? fill_ff - del_total_ff : '0;
   assign rank_bad = KW'(req_ff.live_rank) >= KW'(live);

   // split of the current range and the left child
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign left_node = (node_ff << 1) + NW'(1);

   // filled slots within [lo, mid]
   assign top_full = fill_ff - CW'(1);
   assign top      = (CW'(mid) < top_full) ? mid : top_full[SW-1:0];
   assign filled_left = ((fill_ff == '0) || (top < lo_ff)) ? '0
                      : CW'(top - lo_ff) + CW'(1);

   // live entries in the left half, clamped at zero
   assign left_live = (tree_rd_data < filled_left) ? filled_left - tree_rd_data : '0;
   assign go_left   = KW'(rank_ff) < KW'(left_live);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == TREE_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            case (req_ff.cmd)
               CMD_READ, CMD_DELETE: state_in = rank_bad ? ST_DONE : ST_TREE_RD;
               default:              state_in = ST_DONE;
            endcase
         end
         ST_TREE_RD: begin
            if (lo_ff == hi_ff) begin
               state_in = (req_ff.cmd == CMD_READ) ? ST_VAL_CAP : ST_DONE;
            end else begin
               state_in = ST_TREE_CMP;
            end
         end
         ST_TREE_CMP: begin
            state_in = (!go_left && mark) ? ST_TREE_INC : ST_TREE_RD;
         end
         ST_TREE_INC: state_in = ST_TREE_RD;
         ST_VAL_CAP:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_in       = req_ff;
      result_in    = result_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fill_in      = fill_ff;
      del_total_in = del_total_ff;
      node_in      = node_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rank_in      = rank_ff;
      clr_in       = clr_ff;

      val_wr_en    = 1'b0;
      val_wr_addr  = fill_ff[SW-1:0];
      val_wr_data  = req_ff.item_value;
      val_rd_en    = 1'b0;
      tree_wr_en   = 1'b0;
      tree_wr_addr = node_ff;
      tree_wr_data = tree_rd_data + CW'(1);
      tree_rd_en   = 1'b0;
      tree_rd_addr = left_node;

      case (state_ff)
         ST_CLEAR: begin
            // zero the count tree, one node a cycle
            tree_wr_en   = 1'b1;
            tree_wr_addr = clr_ff;
            tree_wr_data = '0;
            clr_in       = clr_ff + NW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
            end
         end
         ST_DECIDE: begin
            result_in.read_value = '0;
            result_in.status     = STATUS_OK;
            node_in = '0;
            lo_in   = '0;
            hi_in   = SLOT_LAST;
            rank_in = req_ff.live_rank;
            case (req_ff.cmd)
               CMD_APPEND: begin
                  if (fill_ff == CAP_COUNT) begin
                     result_in.status = STATUS_FULL;
                  end else begin
                     val_wr_en = 1'b1;
                     fill_in   = fill_ff + CW'(1);
                  end
               end
               CMD_READ, CMD_DELETE: begin
                  if (rank_bad) begin
                     result_in.status = STATUS_RANK;
                  end else if (mark) begin
                     // count the deletion at the root
                     del_total_in = del_total_ff + CW'(1);
                  end
               end
               default: ;
            endcase
         end
         ST_TREE_RD: begin
            // leaf: fetch the value; otherwise fetch the left child's count
            if (lo_ff == hi_ff) begin
               val_rd_en = (req_ff.cmd == CMD_READ);
            end else begin
               tree_rd_en = 1'b1;
            end
         end
         ST_TREE_CMP: begin
            if (go_left) begin
               node_in      = left_node;
               hi_in        = mid;
               tree_wr_en   = mark;
               tree_wr_addr = left_node;
            end else begin
               node_in      = left_node + NW'(1);
               lo_in        = mid + SW'(1);
               rank_in      = rank_ff - left_live[RANK_W-1:0];
               // fetch the right child's count for the deletion update
               tree_rd_en   = mark;
               tree_rd_addr = left_node + NW'(1);
            end
         end
         ST_TREE_INC: begin
            tree_wr_en = 1'b1;
         end
         ST_VAL_CAP: begin
            result_in.read_value = val_rd_data;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in       = result_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         del_total_ff <= '0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         del_total_ff <= del_total_in;
         clr_ff       <= clr_in;
      end
      req_ff    <= req_in;
      result_ff <= result_in;
      rsp_ff    <= rsp_in;
      node_ff   <= node_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      rank_ff   <= rank_in;
   end

endmodule
